// File: hdl/mntt_pkg.sv
// shared types and constants of the midi note timeout tracker
package mntt_pkg;

	localparam int BUCKET_SIZE = 32;

	// result kinds
	localparam logic [1:0] KIND_MASK = 2'd0;
	localparam logic [1:0] KIND_OFF  = 2'd1;
	localparam logic [1:0] KIND_ON   = 2'd2;

	// configuration register indexes
	localparam logic REG_EXPIRY  = 1'b0;
	localparam logic REG_RETRIG  = 1'b1;

	localparam logic [7:0] EXPIRY_RESET = 8'd5;
	localparam logic [7:0] RETRIG_RESET = 8'd1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  bucket;
		logic [31:0] off_mask;
		logic [6:0]  note_out;
		logic [3:0]  channel_out;
		logic [6:0]  velocity_out;
		logic        last;
	} mntt_result_t;

endpackage

// File: hdl/midi_note_timeout_tracker_top.sv
// midi note timeout tracker: sweep sequencer, active bitmap and configuration
// per request: lookup of the note, then a sweep of all notes giving one off-mask beat
// per bucket of 32, then a note-off beat on retrigger and a note-on beat on (re)start
// the sweep reads one start time per cycle from the single memory read port, holding
// when a bucket's beat waits for the output register; requests are taken only in idle
// reset: active bitmap cleared, expiry 5, retrigger 1; start times undefined
module midi_note_timeout_tracker_top
	import mntt_pkg::*;
#(
	parameter int NUM_NOTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  note,
	input  logic [3:0]  channel,
	input  logic [6:0]  velocity,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [1:0]  bucket,
	output logic [31:0] off_mask,
	output logic [6:0]  note_out,
	output logic [3:0]  channel_out,
	output logic [6:0]  velocity_out,
	output logic        last
);

	localparam int AW = $clog2(NUM_NOTES);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_NOTES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_SWEEP,
		ST_MSG_OFF,
		ST_MSG_ON
	} state_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_ON,
		ACT_OFFON
	} action_t;

	state_t        state_q;
	action_t       act_q;
	action_t       act_d;
	logic [6:0]    note_q;
	logic [3:0]    chan_q;
	logic [6:0]    vel_q;
	logic [31:0]   now_q;
	logic [7:0]    expiry_q;
	logic [7:0]    retrig_q;
	logic [NUM_NOTES-1:0] active_q;
	logic [31:0]   mask_q;
	logic [AW-1:0] rd_addr_q;
	logic          issue_q;
	logic          sweep_vld_s1;
	logic [AW-1:0] sweep_idx_s1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	logic          wr_en;
	logic [31:0]   age;
	logic          note_ok;
	logic          sweep_end;
	logic          stall;
	logic          sweep_go;
	logic          expired_s1;
	logic [31:0]   cur_bit;
	logic          out_load;
	logic          out_free;
	mntt_result_t  out_d;
	mntt_result_t  out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	assign age        = now_q - rd_data;
	assign note_ok    = (int'(note_q) < NUM_NOTES);
	assign sweep_end  = sweep_vld_s1 && (sweep_idx_s1[4:0] == 5'd31 || sweep_idx_s1 == LAST_IDX);
	assign stall      = (state_q == ST_SWEEP) && sweep_end && !out_free;
	assign sweep_go   = (state_q == ST_SWEEP) && sweep_vld_s1 && !stall;
	assign expired_s1 = active_q[sweep_idx_s1] && (age >= {24'd0, expiry_q});
	assign cur_bit    = 32'd1 << sweep_idx_s1[4:0];

	// decision for the requested note, taken before the sweep runs
	always_comb begin
		if (!note_ok) begin
			act_d = ACT_NONE;
		end else if (!active_q[note_q[AW-1:0]] || age >= {24'd0, expiry_q}) begin
			act_d = ACT_ON;
		end else if (age >= {24'd0, retrig_q}) begin
			act_d = ACT_OFFON;
		end else begin
			act_d = ACT_NONE;
		end
	end

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = rd_addr_q;
		wr_en    = 1'b0;
		out_load = 1'b0;
		out_d.kind         = KIND_MASK;
		out_d.bucket       = note_q[6:5];
		out_d.off_mask     = '0;
		out_d.note_out     = note_q;
		out_d.channel_out  = chan_q;
		out_d.velocity_out = vel_q;
		out_d.last         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_en   = in_valid;
				rd_addr = note[AW-1:0];
			end
			ST_PRE: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_SWEEP: begin
				rd_en          = sweep_go && issue_q;
				out_load       = sweep_go && sweep_end;
				out_d.kind     = KIND_MASK;
				out_d.bucket   = 2'({2'b00, sweep_idx_s1} >> 5);
				out_d.off_mask = mask_q | (expired_s1 ? cur_bit : 32'd0);
				out_d.note_out = '0;
				out_d.last     = (sweep_idx_s1 == LAST_IDX) && (act_q == ACT_NONE);
			end
			ST_MSG_OFF: begin
				out_load   = out_free;
				out_d.kind = KIND_OFF;
			end
			ST_MSG_ON: begin
				out_load   = out_free;
				wr_en      = out_free;
				out_d.kind = KIND_ON;
				out_d.last = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= ACT_NONE;
			active_q     <= '0;
			mask_q       <= '0;
			rd_addr_q    <= '0;
			issue_q      <= 1'b0;
			sweep_vld_s1 <= 1'b0;
			sweep_idx_s1 <= '0;
			note_q       <= '0;
			chan_q       <= '0;
			vel_q        <= '0;
			now_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						note_q  <= note;
						chan_q  <= channel;
						vel_q   <= velocity;
						now_q   <= now_seconds;
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					act_q        <= act_d;
					mask_q       <= '0;
					sweep_vld_s1 <= 1'b1;
					sweep_idx_s1 <= '0;
					rd_addr_q    <= AW'(1);
					issue_q      <= 1'b1;
					state_q      <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (sweep_go) begin
						if (expired_s1) begin
							active_q[sweep_idx_s1] <= 1'b0;
						end
						mask_q <= sweep_end ? 32'd0 : (mask_q | (expired_s1 ? cur_bit : 32'd0));
						if (issue_q) begin
							sweep_idx_s1 <= rd_addr_q;
							rd_addr_q    <= rd_addr_q + AW'(1);
							issue_q      <= (rd_addr_q != LAST_IDX);
						end
						if (sweep_idx_s1 == LAST_IDX) begin
							sweep_vld_s1 <= 1'b0;
							case (act_q)
								ACT_OFFON: state_q <= ST_MSG_OFF;
								ACT_ON:    state_q <= ST_MSG_ON;
								default:   state_q <= ST_IDLE;
							endcase
						end
					end
				end
				ST_MSG_OFF: begin
					if (out_free) begin
						state_q <= ST_MSG_ON;
					end
				end
				ST_MSG_ON: begin
					if (out_free) begin
						active_q[note_q[AW-1:0]] <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= EXPIRY_RESET;
			retrig_q <= RETRIG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EXPIRY: expiry_q <= cfg_data;
				REG_RETRIG: retrig_q <= cfg_data;
				default:    expiry_q <= expiry_q;
			endcase
		end
	end

	mntt_time_ram #(
		.DEPTH(NUM_NOTES),
		.AW(AW)
	) u_time_ram (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(note_q[AW-1:0]),
		.wr_data(now_q)
	);

	mntt_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(out_load),
		.d(out_d),
		.free(out_free),
		.valid(out_valid),
		.ready(out_ready),
		.q(out_q)
	);

	assign kind         = out_q.kind;
	assign bucket       = out_q.bucket;
	assign off_mask     = out_q.off_mask;
	assign note_out     = out_q.note_out;
	assign channel_out  = out_q.channel_out;
	assign velocity_out = out_q.velocity_out;
	assign last         = out_q.last;

`ifndef SYNTHESIS
	// a start time is written only together with the note-on beat
	a_write_with_on: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_MSG_ON && out_load))
		else $error("start time written outside note-on");

	// a stalled sweep must not disturb the held read data
	a_stall_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !rd_en)
		else $error("memory read issued during sweep stall");

	// a beat is loaded only when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

	a_accept_pre: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_PRE))
		else $error("accepted request did not start lookup");
`endif

endmodule

// File: hdl/mntt_time_ram.sv
// start time memory, one write port and one registered read port
module mntt_time_ram #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// data holds while no read is issued
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/mntt_out_reg.sv
// output register that parts the result channel from the sequencer
module mntt_out_reg
	import mntt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  mntt_result_t d,
	output logic         free,
	output logic         valid,
	input  logic         ready,
	output mntt_result_t q
);

	logic         valid_q;
	mntt_result_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule
